// ----- hw/rtl/ctcg_pkg.sv -----
// ctcg_pkg: widths, constants and shared types of the greedy CTC decoder.
// No dependencies; all ctcg_* modules and ctc_greedy_decoder refer to it by scoped names.
`default_nettype none

package ctcg_pkg;

  localparam int unsigned CLASS_W = 13;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned CNT_W   = 10;
  localparam int unsigned SUM_W   = 25;
  localparam int unsigned CFG_W   = 14;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned MAX_CLASSES = 8192;
  localparam int unsigned MAX_STEPS   = 512;

  localparam logic [CFG_W-1:0] CLASS_COUNT_RST = 14'd6625;
  localparam logic [CFG_W-1:0] DICT_SIZE_RST   = 14'd6625;

  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DICT_SIZE   = 1'b1;

  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Result queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  // Average divider: quotient fits SCORE_W bits, one bit per cycle
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned DIV_CNT_W = 4;

  typedef struct packed {
    logic               kind;
    logic [CLASS_W-1:0] cls;
    logic [SCORE_W-1:0] score;
    logic [CNT_W-1:0]   count;
    logic               last;
    logic [SUM_W-1:0]   sum;
  } entry_t;

  typedef struct packed {
    logic [1:0] num;
    entry_t     e0;
    entry_t     e1;
  } push_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ctcg_front.sv -----
// ctcg_front: config registers, per-step argmax, repeat collapse and sequence totals.
// Depends on ctcg_pkg; pushes decoded characters and summary requests into ctcg_queue.
`default_nettype none

module ctcg_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [ctcg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [ctcg_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire                          in_valid_i,
  input  wire [ctcg_pkg::SCORE_W-1:0]   in_score_i,
  input  wire                          in_end_i,
  input  wire                          room_i,
  output logic                         in_ready_o,
  output ctcg_pkg::push_t              push_o
);

  logic [ctcg_pkg::CFG_W-1:0]   class_count_q, dict_size_q;
  logic [ctcg_pkg::CLASS_W-1:0] class_counter_q, class_counter_d;
  logic [ctcg_pkg::SCORE_W-1:0] best_score_q, best_score_d;
  logic [ctcg_pkg::CLASS_W-1:0] best_class_q, best_class_d;
  logic [ctcg_pkg::CLASS_W-1:0] prev_class_q, prev_class_d;
  logic                         prev_valid_q, prev_valid_d;
  logic [ctcg_pkg::SUM_W-1:0]   sum_q, sum_d;
  logic [ctcg_pkg::CNT_W-1:0]   total_q, total_d;

  logic [ctcg_pkg::CFG_W-1:0]   eff;
  logic [ctcg_pkg::CFG_W-1:0]   c_next;
  logic                         take, upd, step_end, novel, emit;
  ctcg_pkg::entry_t             char_e, sum_e;

  assign in_ready_o = room_i;
  assign take       = in_valid_i && room_i;

  always_comb begin
    eff = (class_count_q > ctcg_pkg::CFG_W'(ctcg_pkg::MAX_CLASSES))
        ? ctcg_pkg::CFG_W'(ctcg_pkg::MAX_CLASSES) : class_count_q;
    c_next   = {1'b0, class_counter_q} + ctcg_pkg::CFG_W'(1);
    step_end = !(c_next < eff) || in_end_i;

    upd          = (class_counter_q == '0) || (in_score_i > best_score_q);
    best_score_d = upd ? in_score_i : best_score_q;
    best_class_d = upd ? class_counter_q : best_class_q;

    novel = (best_class_d != '0) && !(prev_valid_q && (best_class_d == prev_class_q));
    emit  = step_end && novel && ({1'b0, best_class_d} < dict_size_q)
         && (total_q < ctcg_pkg::CNT_W'(ctcg_pkg::MAX_STEPS));

    sum_d   = sum_q + (emit ? ctcg_pkg::SUM_W'(best_score_d) : '0);
    total_d = total_q + (emit ? ctcg_pkg::CNT_W'(1) : '0);

    class_counter_d = step_end ? '0 : c_next[ctcg_pkg::CLASS_W-1:0];
    prev_class_d    = prev_class_q;
    prev_valid_d    = prev_valid_q;
    if (step_end && (best_class_d == '0)) begin
      prev_class_d = '0;
      prev_valid_d = 1'b1;
    end else if (step_end && novel) begin
      prev_class_d = best_class_d;
      prev_valid_d = 1'b1;
    end

    char_e.kind  = ctcg_pkg::KIND_CHAR;
    char_e.cls   = best_class_d;
    char_e.score = best_score_d;
    char_e.count = total_d;
    char_e.last  = !in_end_i;
    char_e.sum   = '0;

    sum_e.kind  = ctcg_pkg::KIND_SUMMARY;
    sum_e.cls   = '0;
    sum_e.score = '0;
    sum_e.count = total_d;
    sum_e.last  = 1'b1;
    sum_e.sum   = sum_d;

    push_o.e0  = emit ? char_e : sum_e;
    push_o.e1  = sum_e;
    push_o.num = take ? (2'(emit) + 2'(in_end_i)) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_count_q <= ctcg_pkg::CLASS_COUNT_RST;
      dict_size_q   <= ctcg_pkg::DICT_SIZE_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ctcg_pkg::CFG_CLASS_COUNT) begin
        class_count_q <= cfg_data_i;
      end else if (cfg_idx_i == ctcg_pkg::CFG_DICT_SIZE) begin
        dict_size_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_counter_q <= '0;
      best_score_q    <= '0;
      best_class_q    <= '0;
      prev_class_q    <= '0;
      prev_valid_q    <= 1'b0;
      sum_q           <= '0;
      total_q         <= '0;
    end else if (take) begin
      if (in_end_i) begin
        // summary queued: drop all sequence state
        class_counter_q <= '0;
        best_score_q    <= '0;
        best_class_q    <= '0;
        prev_class_q    <= '0;
        prev_valid_q    <= 1'b0;
        sum_q           <= '0;
        total_q         <= '0;
      end else begin
        class_counter_q <= class_counter_d;
        best_score_q    <= best_score_d;
        best_class_q    <= best_class_d;
        prev_class_q    <= prev_class_d;
        prev_valid_q    <= prev_valid_d;
        sum_q           <= sum_d;
        total_q         <= total_d;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ctcg_queue.sv -----
// ctcg_queue: short result queue taking up to two entries and giving one per cycle when popped.
// Depends on ctcg_pkg; sits between ctcg_front and ctcg_back.
`default_nettype none

module ctcg_queue (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire ctcg_pkg::push_t  push_i,
  input  wire                   pop_i,
  output logic                  room_o,
  output logic                  head_valid_o,
  output ctcg_pkg::entry_t      head_o
);

  ctcg_pkg::entry_t                 entries_q [ctcg_pkg::QUEUE_DEPTH];
  logic [ctcg_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q, wr_ptr1;
  logic [ctcg_pkg::QCNT_W-1:0]      count_q;
  logic                             do_pop;

  assign head_valid_o = (count_q != '0);
  assign head_o       = entries_q[rd_ptr_q];
  // room for the worst case of a character plus a summary
  assign room_o       = (count_q <= ctcg_pkg::QCNT_W'(ctcg_pkg::QUEUE_DEPTH - 2));
  assign do_pop       = pop_i && head_valid_o;
  assign wr_ptr1      = wr_ptr_q + ctcg_pkg::QPTR_W'(1);

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      entries_q[wr_ptr_q] <= push_i.e0;
    end
    if (push_i.num == 2'd2) begin
      entries_q[wr_ptr1] <= push_i.e1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + ctcg_pkg::QPTR_W'(push_i.num);
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + ctcg_pkg::QPTR_W'(1);
      end
      count_q <= count_q + ctcg_pkg::QCNT_W'(push_i.num) - ctcg_pkg::QCNT_W'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ctcg_back.sv -----
// ctcg_back: drains the result queue, divides the score sum for summaries, drives the output.
// Depends on ctcg_pkg; fed by ctcg_queue.
`default_nettype none

module ctcg_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          head_valid_i,
  input  wire ctcg_pkg::entry_t        head_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic                         out_kind_o,
  output logic [ctcg_pkg::CLASS_W-1:0] out_cls_o,
  output logic [ctcg_pkg::SCORE_W-1:0] out_score_o,
  output logic [ctcg_pkg::CNT_W-1:0]   out_count_o,
  output logic                         out_last_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e                         state_q, state_d;
  logic [ctcg_pkg::CNT_W-1:0]     rem_q, rem_d;
  logic [ctcg_pkg::SCORE_W-1:0]   quo_q, quo_d;
  logic [ctcg_pkg::CNT_W-1:0]     divisor_q, divisor_d;
  logic [ctcg_pkg::DIV_CNT_W-1:0] step_q, step_d;
  logic                           out_valid_q;
  logic                           kind_q, last_q;
  logic [ctcg_pkg::CLASS_W-1:0]   cls_q;
  logic [ctcg_pkg::SCORE_W-1:0]   score_q;
  logic [ctcg_pkg::CNT_W-1:0]     count_q;

  logic                           out_free, needs_div, load;
  logic [ctcg_pkg::CNT_W:0]       trial;
  logic                           q_bit;
  ctcg_pkg::entry_t               ld_e;

  assign out_free  = !out_valid_q || out_ready_i;
  assign pop_o     = (state_q == ST_IDLE) && head_valid_i && out_free;
  assign needs_div = (head_i.kind == ctcg_pkg::KIND_SUMMARY) && (head_i.count != '0);

  always_comb begin
    trial = {rem_q, quo_q[ctcg_pkg::SCORE_W-1]};
    q_bit = (trial >= {1'b0, divisor_q});

    state_d   = state_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    divisor_d = divisor_q;
    step_d    = step_q;
    load      = 1'b0;
    ld_e      = head_i;

    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          if (needs_div) begin
            // high part of the sum is already below the count
            rem_d     = ctcg_pkg::CNT_W'(head_i.sum[ctcg_pkg::SUM_W-1:ctcg_pkg::SCORE_W]);
            quo_d     = head_i.sum[ctcg_pkg::SCORE_W-1:0];
            divisor_d = head_i.count;
            step_d    = '0;
            state_d   = ST_DIV;
          end else begin
            load = 1'b1;
          end
        end
      end
      ST_DIV: begin
        rem_d  = q_bit ? ctcg_pkg::CNT_W'(trial - {1'b0, divisor_q})
                       : trial[ctcg_pkg::CNT_W-1:0];
        quo_d  = {quo_q[ctcg_pkg::SCORE_W-2:0], q_bit};
        step_d = step_q + ctcg_pkg::DIV_CNT_W'(1);
        if (step_q == ctcg_pkg::DIV_CNT_W'(ctcg_pkg::DIV_STEPS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        ld_e.kind  = ctcg_pkg::KIND_SUMMARY;
        ld_e.cls   = '0;
        ld_e.score = quo_q;
        ld_e.count = divisor_q;
        ld_e.last  = 1'b1;
        if (out_free) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    divisor_q <= divisor_d;
    if (load) begin
      kind_q  <= ld_e.kind;
      cls_q   <= ld_e.cls;
      score_q <= ld_e.score;
      count_q <= ld_e.count;
      last_q  <= ld_e.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = kind_q;
  assign out_cls_o   = cls_q;
  assign out_score_o = score_q;
  assign out_count_o = count_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ctc_greedy_decoder.sv -----
// ctc_greedy_decoder: top level of the streaming greedy CTC decoder.
// Depends on ctcg_pkg, ctcg_front, ctcg_queue and ctcg_back.
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid/tready          tdata = class_score, tlast = sequence_end
//   m_axis    out  tvalid/tready          tdata = class_index, score_value,
//                                         decoded_count; tuser = kind; tlast = last
//   cfg       in   cfg_we_i (no wait)     cfg_idx_i, cfg_data_i
//
// One score is taken per cycle while the result queue has room for two entries.
// A character goes through the queue to the output register if none waits ahead.
// A summary with a nonzero count runs the bit-serial divider before it is loaded.
// Output stalls back up through the 4-entry queue into s_axis_tready.
// Reset clears all sequence state and loads both registers with 6625.
`default_nettype none

module ctc_greedy_decoder (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [ctcg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [ctcg_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire [15:0]                     s_axis_tdata,  // class_score
  input  wire                            s_axis_tlast,  // sequence_end
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  output logic [39:0]                    m_axis_tdata,  // class_index, score_value,
                                                        // decoded_count, zero pad
  output logic                           m_axis_tuser,  // result_kind
  output logic                           m_axis_tlast   // last_of_run
);

  ctcg_pkg::push_t              push;
  ctcg_pkg::entry_t             head;
  logic                         room, head_valid, pop;
  logic [ctcg_pkg::CLASS_W-1:0] out_cls;
  logic [ctcg_pkg::SCORE_W-1:0] out_score;
  logic [ctcg_pkg::CNT_W-1:0]   out_count;

  ctcg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_score_i (s_axis_tdata),
    .in_end_i   (s_axis_tlast),
    .room_i     (room),
    .in_ready_o (s_axis_tready),
    .push_o     (push)
  );

  ctcg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .pop_i        (pop),
    .room_o       (room),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  ctcg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (m_axis_tuser),
    .out_cls_o    (out_cls),
    .out_score_o  (out_score),
    .out_count_o  (out_count),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_count, out_score, out_cls};

endmodule

`default_nettype wire

// ----- sim/ctc_greedy_decoder_chk.sv -----
// Checker for the greedy CTC decoder: watches config writes and both streams.
// Predicts the decoded characters and summaries and compares them as they leave.
// Depends on ctcg_pkg for widths, register indexes and result kinds.
`timescale 1ns / 100ps

module ctc_greedy_decoder_chk
  import ctcg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,   // class_score
  input  logic                 s_axis_tlast,   // sequence_end
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [39:0]          m_axis_tdata,   // class_index, score_value, decoded_count
  input  logic                 m_axis_tuser,   // result_kind
  input  logic                 m_axis_tlast,   // last_of_run
  output int                   error_count_o,
  output int                   pending_o
);

  typedef struct packed {
    logic               kind;
    logic [CLASS_W-1:0] cls;
    logic [SCORE_W-1:0] score;
    logic [CNT_W-1:0]   count;
    logic               last;
  } decoded_t;

  decoded_t           decoded_q[$];

  logic [CFG_W-1:0]   classes_per_step;
  logic [CFG_W-1:0]   dict_size;
  logic [CLASS_W-1:0] step_pos;
  logic [CLASS_W-1:0] lead_class;
  logic [SCORE_W-1:0] lead_score;
  logic [CLASS_W-1:0] prev_class;
  logic               prev_known;
  logic [SUM_W-1:0]   seq_sum;
  logic [CNT_W-1:0]   seq_chars;

  initial begin
    error_count_o = 0;
    pending_o     = 0;
  end

  task automatic clear_sequence();
    step_pos   = '0;
    lead_class = '0;
    lead_score = '0;
    prev_class = '0;
    prev_known = 1'b0;
    seq_sum    = '0;
    seq_chars  = '0;
  endtask

  // Fold one score into the running argmax; queue whatever the step end produces.
  task automatic decode_score(input logic [SCORE_W-1:0] sc, input logic seq_end);
    decoded_t    outs[2];
    int          n;
    int unsigned eff_classes;
    n = 0;
    eff_classes = (classes_per_step > MAX_CLASSES) ? MAX_CLASSES : classes_per_step;
    if (step_pos == 0 || sc > lead_score) begin
      lead_score = sc;
      lead_class = step_pos;
    end
    if (int'(step_pos) + 1 < eff_classes && !seq_end) begin
      step_pos = step_pos + 1'b1;
      return;
    end
    step_pos = '0;
    if (lead_class == 0) begin
      prev_class = '0;
      prev_known = 1'b1;
    end else if (!(prev_known && lead_class == prev_class)) begin
      // characters outside the dictionary or past the step limit are dropped but still count as previous
      if (lead_class < dict_size && seq_chars < MAX_STEPS) begin
        seq_sum   = seq_sum + lead_score;
        seq_chars = seq_chars + 1'b1;
        outs[n]   = '{kind: KIND_CHAR, cls: lead_class, score: lead_score,
                      count: seq_chars, last: 1'b0};
        n++;
      end
      prev_class = lead_class;
      prev_known = 1'b1;
    end
    if (seq_end) begin
      outs[n].kind  = KIND_SUMMARY;
      outs[n].cls   = '0;
      outs[n].score = (seq_chars == 0) ? '0 : SCORE_W'(seq_sum / seq_chars);
      outs[n].count = seq_chars;
      outs[n].last  = 1'b0;
      n++;
      clear_sequence();
    end
    if (n > 0) outs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) decoded_q = {decoded_q, outs[i]};
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      error_count_o++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    decoded_t want;
    if (!rst_ni) begin
      classes_per_step = CLASS_COUNT_RST;
      dict_size        = DICT_SIZE_RST;
      clear_sequence();
      decoded_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CLASS_COUNT: classes_per_step = cfg_data_i;
          CFG_DICT_SIZE:   dict_size        = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) decode_score(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          error_count_o++;
          $display({"%0t: unexpected transfer: expected none, ",
                    "got kind %0d class %0d score %0d count %0d"},
                   $time, m_axis_tuser, m_axis_tdata[12:0], m_axis_tdata[28:13],
                   m_axis_tdata[38:29]);
        end else begin
          want = decoded_q.pop_front();
          check_field("result_kind", want.kind, m_axis_tuser);
          check_field("class_index", want.cls, m_axis_tdata[12:0]);
          check_field("score_value", want.score, m_axis_tdata[28:13]);
          check_field("decoded_count", want.count, m_axis_tdata[38:29]);
          check_field("last_of_run", want.last, m_axis_tlast);
          check_field("tdata pad", 0, m_axis_tdata[39]);
        end
      end
    end
    pending_o = decoded_q.size();
  end

endmodule

// ----- sim/ctc_greedy_decoder_tb.sv -----
// Testbench top for ctc_greedy_decoder: clock, reset, config writes and score stimulus.
// Checking lives in ctc_greedy_decoder_chk; depends on ctcg_pkg and the decoder RTL.
`timescale 1ns / 100ps

module ctc_greedy_decoder_tb;
  import ctcg_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 400;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = CFG_CLASS_COUNT;
  logic [CFG_W-1:0]     cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata  = '0;  // class_score
  logic                 s_axis_tlast  = 1'b0;  // sequence_end
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [39:0]          m_axis_tdata;  // class_index, score_value, decoded_count, pad
  logic                 m_axis_tuser;  // result_kind
  logic                 m_axis_tlast;  // last_of_run
  int                   error_count_o;
  int                   pending_o;

  int   cycle_count  = 0;
  int   scores_sent  = 0;
  int   last_winner  = 0;
  logic src_idle_en  = 1'b1;
  logic sink_idle_en = 1'b1;
  logic hold_req     = 1'b0;

  ctc_greedy_decoder uut (.*);
  ctc_greedy_decoder_chk u_chk (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL ctc_greedy_decoder");
      $finish;
    end
  end

  // Result side: random ready bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20) - 1) @(negedge clk_i);
      end
    end
  end

  task automatic send_score(input logic [SCORE_W-1:0] sc, input logic seq_end);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sc;
    s_axis_tlast  <= seq_end;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    scores_sent++;
  endtask

  task automatic send_row(input logic [SCORE_W-1:0] a, input logic [SCORE_W-1:0] b,
                          input logic [SCORE_W-1:0] c, input logic [SCORE_W-1:0] d);
    send_score(a, 1'b0);
    send_score(b, 1'b0);
    send_score(c, 1'b0);
    send_score(d, 1'b0);
  endtask

  // Idle the input, let every expected result arrive, then let the divider settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_o != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] classes, input logic [CFG_W-1:0] dict);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_CLASS_COUNT;
    cfg_data_i <= classes;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_DICT_SIZE;
    cfg_data_i <= dict;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  // One time step whose argmax is winner unless it is noisy; ties only after it, so the first maximum holds.
  task automatic send_step(input int ncls, input int winner, input bit seq_end);
    logic [SCORE_W-1:0] peak;
    int cut;
    int tie_at;
    bit noisy;
    peak   = 16'($urandom_range(1, 65535));
    cut    = ncls;
    noisy  = ($urandom_range(0, 7) == 0);
    if (seq_end && ncls > 1 && $urandom_range(0, 9) == 0) cut = $urandom_range(1, ncls - 1);
    if (winner >= cut) winner = cut - 1;
    tie_at = ($urandom_range(0, 4) == 0) ? winner + 1 + $urandom_range(0, 3) : -1;
    for (int i = 0; i < cut; i++) begin
      if (noisy)
        send_score(16'($urandom()), seq_end && i == cut - 1);
      else if (i == winner || i == tie_at)
        send_score(peak, seq_end && i == cut - 1);
      else if (i < winner)
        send_score(16'($urandom_range(0, peak - 1)), seq_end && i == cut - 1);
      else
        send_score(16'($urandom_range(0, peak)), seq_end && i == cut - 1);
    end
    last_winner = winner;
  endtask

  task automatic run_random_phase(input logic [CFG_W-1:0] classes,
                                  input logic [CFG_W-1:0] dict, input int n_scores);
    int stop_at;
    int nsteps;
    int winner;
    set_config(classes, dict);
    stop_at = scores_sent + n_scores;
    while (scores_sent < stop_at) begin
      if ($urandom_range(0, 19) == 0) begin
        // stray scores with sequence ends at random places
        repeat ($urandom_range(1, 6)) send_score(16'($urandom()), $urandom_range(0, 7) == 0);
      end else begin
        nsteps = $urandom_range(1, 12);
        for (int s = 0; s < nsteps; s++) begin
          case ($urandom_range(0, 3))
            0:       winner = 0;
            1:       winner = last_winner;
            default: winner = $urandom_range(0, classes - 1);
          endcase
          if (winner >= classes) winner = 0;
          send_step(classes, winner, s == nsteps - 1);
        end
      end
    end
    send_score(16'($urandom()), 1'b1);
    drain_results();
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Sequence end on the first score under reset settings: no character decoded, only a summary.
    send_score(16'hFFFF, 1'b1);
    drain_results();

    set_config(14'd4, 14'd3);
    send_row(16'h0000, 16'h1000, 16'hFFFF, 16'h0001);  // class 2 emitted
    send_row(16'h0000, 16'h0001, 16'hFFFF, 16'h0000);  // repeat collapsed
    send_row(16'h0005, 16'h0009, 16'h0009, 16'h0000);  // tie, class 1 wins
    send_row(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);  // blank clears repeat memory
    send_row(16'h0000, 16'h8000, 16'h0000, 16'h0000);  // class 1 again
    send_row(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);  // outside dictionary
    send_score(16'h0000, 1'b0);
    send_score(16'h8000, 1'b1);                        // early end mid-step
    drain_results();

    // Fewer than two classes: every score is a blank step.
    set_config(14'd0, 14'd5);
    send_score(16'hFFFF, 1'b0);
    send_score(16'h1234, 1'b1);
    drain_results();
    set_config(14'd1, 14'd5);
    send_score(16'hABCD, 1'b0);
    send_score(16'hFFFF, 1'b1);
    drain_results();

    // Empty dictionary: no character is emitted, only the summary.
    set_config(14'd4, 14'd0);
    send_step(4, 1, 1'b0);
    send_step(4, 3, 1'b1);
    drain_results();

    // Class count above the limit: the step here ends early on the sequence end.
    set_config(14'h3FFF, 14'h3FFF);
    for (int i = 0; i < 6; i++) send_score((i == 5) ? 16'hF000 : 16'h0100, i == 5);
    drain_results();

    // Alternate two classes past the character limit.
    set_config(14'd3, 14'd8192);
    for (int k = 0; k < MAX_STEPS + 3; k++) send_step(3, (k % 2) ? 2 : 1, k == MAX_STEPS + 2);
    drain_results();

    hold_req = 1'b1;
    run_random_phase(14'd2, 14'd2, 60);
    run_random_phase(14'd3, 14'd3, 10);
    run_random_phase(14'd5, 14'd4, 10);
    run_random_phase(14'd12, 14'd10, 10);
    run_random_phase(14'd2, 14'd1, 10);
    run_random_phase(14'd6, 14'd8192, 10);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    run_random_phase(14'd8, 14'h3FFF, 10);

    if (error_count_o == 0) begin
      $display("PASS ctc_greedy_decoder");
    end else begin
      $display("FAIL ctc_greedy_decoder");
    end
    $finish;
  end

endmodule
